// ----- rtl/pfe_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and key square lookup functions for the Playfair
// stream encryptor. No dependencies.
package pfe_pkg;

    localparam int KeyRows    = 5;
    localparam int KeyCols    = 5;
    localparam int CodeW      = 5;
    localparam int KeyW       = KeyCols * CodeW;
    localparam int CfgIdxW    = 3;
    localparam int QueueDepth = 4;

    typedef logic [CodeW-1:0] code_t;
    typedef logic [KeyRows-1:0][KeyW-1:0] key_t;
    typedef logic [2:0] pos_t;

    localparam code_t CODE_I = 5'd8;
    localparam code_t CODE_J = 5'd9;
    localparam code_t CODE_X = 5'd23;

    localparam logic [7:0] ChUpperA = 8'h41;
    localparam logic [7:0] ChUpperZ = 8'h5A;
    localparam logic [7:0] ChLowerA = 8'h61;
    localparam logic [7:0] ChLowerZ = 8'h7A;
    localparam logic [6:0] AsciiBase = 7'h41;

    localparam key_t KeyReset = {25'd2149955, 25'd6848868, 25'd25942713,
                                 25'd17283508, 25'd10755244};

    typedef enum logic [CfgIdxW-1:0] {
        REG_KEY_ROW0 = 3'd0,
        REG_KEY_ROW1 = 3'd1,
        REG_KEY_ROW2 = 3'd2,
        REG_KEY_ROW3 = 3'd3,
        REG_KEY_ROW4 = 3'd4
    } cfg_reg_e;

    typedef enum logic [1:0] {
        STG_EMPTY,
        STG_FIRST,
        STG_SECOND
    } stage_e;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_message;
    } in_t;

    typedef struct packed {
        logic [6:0] cipher_char;
        logic       last_out;
    } out_t;

    typedef struct packed {
        code_t first;
        code_t second;
        logic  last;
    } pair_t;

    typedef struct packed {
        logic [1:0] count;
        pair_t      pair0;
        pair_t      pair1;
    } queue_wr_t;

    typedef struct packed {
        pos_t row;
        pos_t col;
    } loc_t;

    function automatic pos_t pos_inc(pos_t p);
        return (p == pos_t'(KeyCols - 1)) ? '0 : pos_t'(p + pos_t'(1));
    endfunction

    function automatic code_t key_cell(key_t key, pos_t r, pos_t c);
        return key[r][CodeW*c +: CodeW];
    endfunction

    // Scan backward so the first row-major match is the one kept.
    function automatic loc_t key_locate(key_t key, code_t code);
        loc_t loc;
        loc = '0;
        for (int r = KeyRows - 1; r >= 0; r--) begin
            for (int c = KeyCols - 1; c >= 0; c--) begin
                if (key[r][CodeW*c +: CodeW] == code) begin
                    loc.row = pos_t'(r);
                    loc.col = pos_t'(c);
                end
            end
        end
        return loc;
    endfunction

endpackage

// ----- rtl/pfe_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts plaintext bytes, filters and folds letters, inserts X
// and forms letter pairs for the pair queue. Depends on pfe_pkg.
module pfe_front import pfe_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_t       s_data,
    input  logic      q_space,
    output queue_wr_t q_wr
);

    code_t pending_letter_reg, pending_letter_next;
    logic  pending_valid_reg, pending_valid_next;
    code_t previous_letter_reg, previous_letter_next;
    logic  previous_valid_reg, previous_valid_next;

    logic       fire;
    logic       is_upper;
    logic       is_lower;
    logic       is_letter;
    code_t      code;
    logic [1:0] push_en;
    code_t      push_code [2];
    pair_t      pairs [2];
    logic [1:0] n;
    code_t      p_l;
    logic       p_v;

    assign s_ready = q_space;
    assign fire    = s_valid && s_ready;

    always_comb begin
        is_upper = (s_data.char_in >= ChUpperA) && (s_data.char_in <= ChUpperZ);
        is_lower = (s_data.char_in >= ChLowerA) && (s_data.char_in <= ChLowerZ);
        is_letter = is_upper || is_lower;
        code = is_upper ? code_t'(s_data.char_in - ChUpperA)
                        : code_t'(s_data.char_in - ChLowerA);
        if (code == CODE_J) begin
            code = CODE_I;
        end

        push_en[0]   = is_letter && previous_valid_reg && (previous_letter_reg == code);
        push_code[0] = CODE_X;
        push_en[1]   = is_letter;
        push_code[1] = code;

        p_l      = pending_letter_reg;
        p_v      = pending_valid_reg;
        n        = '0;
        pairs[0] = '0;
        pairs[1] = '0;
        for (int i = 0; i < 2; i++) begin
            if (push_en[i]) begin
                if (p_v) begin
                    pairs[n[0]].first  = p_l;
                    pairs[n[0]].second = push_code[i];
                    n   = n + 2'd1;
                    p_v = 1'b0;
                end else begin
                    p_l = push_code[i];
                    p_v = 1'b1;
                end
            end
        end
        // pad a lone letter at end of message
        if (s_data.end_of_message && p_v) begin
            pairs[n[0]].first  = p_l;
            pairs[n[0]].second = CODE_X;
            n   = n + 2'd1;
            p_v = 1'b0;
        end
        if (s_data.end_of_message && (n != 2'd0)) begin
            pairs[n[0] ^ 1'b1].last = 1'b1;
        end

        q_wr.count = fire ? n : 2'd0;
        q_wr.pair0 = pairs[0];
        q_wr.pair1 = pairs[1];

        pending_letter_next  = pending_letter_reg;
        pending_valid_next   = pending_valid_reg;
        previous_letter_next = previous_letter_reg;
        previous_valid_next  = previous_valid_reg;
        if (fire) begin
            if (s_data.end_of_message) begin
                pending_letter_next  = '0;
                pending_valid_next   = 1'b0;
                previous_letter_next = '0;
                previous_valid_next  = 1'b0;
            end else begin
                pending_letter_next = p_l;
                pending_valid_next  = p_v;
                if (is_letter) begin
                    previous_letter_next = code;
                    previous_valid_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_letter_reg  <= '0;
            pending_valid_reg   <= 1'b0;
            previous_letter_reg <= '0;
            previous_valid_reg  <= 1'b0;
        end else begin
            pending_letter_reg  <= pending_letter_next;
            pending_valid_reg   <= pending_valid_next;
            previous_letter_reg <= previous_letter_next;
            previous_valid_reg  <= previous_valid_next;
        end
    end

endmodule

// ----- rtl/pfe_queue.sv -----
`timescale 1ns / 1ps
// Pair queue between front and back end: up to two writes and one read per
// cycle. Depends on pfe_pkg.
module pfe_queue import pfe_pkg::*; #(
    parameter int DEPTH = QueueDepth
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  queue_wr_t                  q_wr,
    output logic                       q_space,
    output logic                       rd_valid,
    output pair_t                      rd_pair,
    input  logic                       rd_pop,
    output logic [$clog2(DEPTH+1)-1:0] q_count
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    pair_t            mem [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic [PtrW-1:0]  wr_ptr_inc;

    function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
        return (p == PtrW'(DEPTH - 1)) ? '0 : PtrW'(p + PtrW'(1));
    endfunction

    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);
    assign q_space    = (count_reg <= CntW'(DEPTH - 2));
    assign rd_valid   = (count_reg != '0);
    assign rd_pair    = mem[rd_ptr_reg];
    assign q_count    = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        case (q_wr.count)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = rd_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = CntW'(count_reg + CntW'(q_wr.count) - CntW'(rd_pop));
    end

    always_ff @(posedge aclk) begin
        if (q_wr.count != 2'd0) begin
            mem[wr_ptr_reg] <= q_wr.pair0;
        end
        if (q_wr.count == 2'd2) begin
            mem[wr_ptr_inc] <= q_wr.pair1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/pfe_back.sv -----
`timescale 1ns / 1ps
// Back end: enciphers one letter pair against the key square and delivers
// the two cipher letters through an output register. Depends on pfe_pkg.
module pfe_back import pfe_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  key_t  key,
    input  logic  rd_valid,
    input  pair_t rd_pair,
    output logic  rd_pop,
    output logic  m_valid,
    input  logic  m_ready,
    output out_t  m_data
);

    stage_e state_reg, state_next;
    code_t  c0_reg, c1_reg;
    logic   last_reg;
    logic   m_valid_reg, m_valid_next;
    out_t   m_data_reg, m_data_next;

    loc_t   la, lb;
    code_t  e0, e1;
    logic   m_free;
    logic   out_load;

    always_comb begin
        la = key_locate(key, rd_pair.first);
        lb = key_locate(key, rd_pair.second);
        if (la.row == lb.row) begin
            e0 = key_cell(key, la.row, pos_inc(la.col));
            e1 = key_cell(key, lb.row, pos_inc(lb.col));
        end else if (la.col == lb.col) begin
            e0 = key_cell(key, pos_inc(la.row), la.col);
            e1 = key_cell(key, pos_inc(lb.row), lb.col);
        end else begin
            e0 = key_cell(key, la.row, lb.col);
            e1 = key_cell(key, lb.row, la.col);
        end
    end

    assign m_free   = !m_valid_reg || m_ready;
    assign out_load = m_free && (state_reg != STG_EMPTY);

    always_comb begin
        state_next = state_reg;
        rd_pop     = 1'b0;
        unique case (state_reg)
            STG_EMPTY: begin
                rd_pop = rd_valid;
                if (rd_valid) begin
                    state_next = STG_FIRST;
                end
            end
            STG_FIRST: begin
                if (m_free) begin
                    state_next = STG_SECOND;
                end
            end
            STG_SECOND: begin
                if (m_free) begin
                    rd_pop     = rd_valid;
                    state_next = rd_valid ? STG_FIRST : STG_EMPTY;
                end
            end
            default: state_next = STG_EMPTY;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            if (state_reg == STG_FIRST) begin
                m_data_next.cipher_char = 7'(AsciiBase + {2'b00, c0_reg});
                m_data_next.last_out    = 1'b0;
            end else begin
                m_data_next.cipher_char = 7'(AsciiBase + {2'b00, c1_reg});
                m_data_next.last_out    = last_reg;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STG_EMPTY;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (rd_pop) begin
            c0_reg   <= e0;
            c1_reg   <= e1;
            last_reg <= rd_pair.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/playfair_stream_encrypt.sv -----
`timescale 1ns / 1ps
// Top level of the Playfair stream encryptor: key square registers, front
// end, pair queue and back end. Depends on pfe_pkg and the pfe_* modules.
//
// Input channel s_*: one plaintext byte per transaction with an end of message
// flag. Non-letters are dropped, case is folded, J maps to I, X goes between
// repeated letters and pads a lone letter at end of message.
// Output channel m_*: one uppercase cipher letter per transaction; last_out
// marks the final letter of a message (absent if the message emitted none).
// Configuration: cfg_wen writes cfg_wdata into key row cfg_index (0..4) of the
// 5x5 square; write only while the block is idle.
// Flow: the first cipher letter of a byte that completes a pair moves from
// the pair queue through the back end's pair register to the output register.
// The back end delivers one letter per cycle while the output port accepts,
// so a byte yields 0, 2 or 4 cipher letters; the output port sets the
// sustained rate. A byte is accepted whenever the queue has room for two pairs.
// Reset: aresetn (synchronous, active low) empties the queue and output
// register, clears the half pair and loads the default key square.
// A stalled receiver holds the output register; the queue then fills and
// s_ready drops until letters drain.
module playfair_stream_encrypt import pfe_pkg::*; #(
    parameter int QUEUE_DEPTH = QueueDepth
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_t                s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_t               m_data,
    input  logic               cfg_wen,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [KeyW-1:0]    cfg_wdata
);

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    key_t            key_reg, key_next;
    queue_wr_t       q_wr;
    logic            q_space;
    logic            rd_valid;
    pair_t           rd_pair;
    logic            rd_pop;
    logic [CntW-1:0] q_count;

    always_comb begin
        key_next = key_reg;
        if (cfg_wen) begin
            unique case (cfg_reg_e'(cfg_index))
                REG_KEY_ROW0: key_next[0] = cfg_wdata;
                REG_KEY_ROW1: key_next[1] = cfg_wdata;
                REG_KEY_ROW2: key_next[2] = cfg_wdata;
                REG_KEY_ROW3: key_next[3] = cfg_wdata;
                REG_KEY_ROW4: key_next[4] = cfg_wdata;
                default:      key_next    = key_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= KeyReset;
        end else begin
            key_reg <= key_next;
        end
    end

    pfe_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_space (q_space),
        .q_wr    (q_wr)
    );

    pfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_wr     (q_wr),
        .q_space  (q_space),
        .rd_valid (rd_valid),
        .rd_pair  (rd_pair),
        .rd_pop   (rd_pop),
        .q_count  (q_count)
    );

    pfe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .key      (key_reg),
        .rd_valid (rd_valid),
        .rd_pair  (rd_pair),
        .rd_pop   (rd_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= CntW'(QUEUE_DEPTH))
        else $error("pair queue overfilled");

    a_write_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_wr.count != 2'd0) |-> (s_valid && s_ready))
        else $error("pair written without an input transaction");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (q_count == CntW'($past(q_count) + CntW'($past(q_wr.count))
                              - CntW'($past(rd_pop)))))
        else $error("pair queue count lost track");

endmodule

// ----- tb/sv/playfair_stream_encrypt_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for playfair_stream_encrypt: streams plaintext bytes,
// predicts the cipher letters in step and compares every output transaction.
// Depends on pfe_pkg and the encryptor RTL.
module playfair_stream_encrypt_test;
    import pfe_pkg::*;

    localparam int Settle     = 10;
    localparam int CycleLimit = 200000;
    localparam int FreezeLen  = 300;
    localparam int ReportMax  = 10;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    in_t                s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    out_t               m_data;
    logic               cfg_wen   = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [KeyW-1:0]    cfg_wdata = '0;

    int         src_idle_pct  = 0;
    int         snk_stall_pct = 0;
    int         freeze_seq    = 0;
    int         freeze_seen   = 0;
    int         freeze_left   = 0;
    int         cycle_cnt     = 0;
    int         fault_cnt     = 0;
    logic [7:0] last_pick     = "A";

    // cipher predictor state
    key_t  sq_rows    = KeyReset;
    code_t held_code  = '0;
    logic  held_ok    = 1'b0;
    code_t prior_code = '0;
    logic  prior_ok   = 1'b0;
    out_t  cipher_q[$];

    playfair_stream_encrypt uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic code_t sq_cell(int r, int c);
        return sq_rows[r % 5][CodeW * (c % 5) +: CodeW];
    endfunction

    function automatic void find_code(code_t code, output int r, output int c);
        logic hit;
        hit = 1'b0;
        r = 0;
        c = 0;
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 5; j++) begin
                if (!hit && sq_cell(i, j) == code) begin
                    r = i;
                    c = j;
                    hit = 1'b1;
                end
            end
        end
    endfunction

    function automatic void emit_letter(code_t code);
        out_t e;
        e.cipher_char = AsciiBase + 7'(code);
        e.last_out = 1'b0;
        cipher_q.push_back(e);
    endfunction

    function automatic int pair_in(code_t code);
        int r1, c1, r2, c2;
        if (!held_ok) begin
            held_code = code;
            held_ok = 1'b1;
            return 0;
        end
        held_ok = 1'b0;
        find_code(held_code, r1, c1);
        find_code(code, r2, c2);
        if (r1 == r2) begin
            emit_letter(sq_cell(r1, c1 + 1));
            emit_letter(sq_cell(r2, c2 + 1));
        end else if (c1 == c2) begin
            emit_letter(sq_cell(r1 + 1, c1));
            emit_letter(sq_cell(r2 + 1, c2));
        end else begin
            emit_letter(sq_cell(r1, c2));
            emit_letter(sq_cell(r2, c1));
        end
        return 2;
    endfunction

    function automatic void encipher_byte(in_t item);
        int    n;
        logic  letter;
        code_t code;
        out_t  tail;
        n = 0;
        letter = 1'b0;
        code = '0;
        if (item.char_in >= ChUpperA && item.char_in <= ChUpperZ) begin
            letter = 1'b1;
            code = code_t'(item.char_in - ChUpperA);
        end else if (item.char_in >= ChLowerA && item.char_in <= ChLowerZ) begin
            letter = 1'b1;
            code = code_t'(item.char_in - ChLowerA);
        end
        if (letter) begin
            if (code == CODE_J)
                code = CODE_I;
            if (prior_ok && prior_code == code)
                n += pair_in(CODE_X);
            n += pair_in(code);
            prior_code = code;
            prior_ok = 1'b1;
        end
        if (item.end_of_message) begin
            if (held_ok)
                n += pair_in(CODE_X);
            held_ok = 1'b0;
            held_code = '0;
            prior_ok = 1'b0;
            prior_code = '0;
            if (n > 0) begin
                tail = cipher_q.pop_back();
                tail.last_out = 1'b1;
                cipher_q.push_back(tail);
            end
        end
    endfunction

    function automatic void note_fault(string msg);
        fault_cnt++;
        if (fault_cnt <= ReportMax)
            $display("%0t: %s", $realtime, msg);
    endfunction

    always @(posedge aclk) begin : check_letters
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (cipher_q.size() == 0) begin
                note_fault($sformatf("unexpected letter: char %0d last %0b",
                                     m_data.cipher_char, m_data.last_out));
            end else begin
                want = cipher_q.pop_front();
                if (want.cipher_char != m_data.cipher_char)
                    note_fault($sformatf("cipher_char: expected %0d, got %0d",
                                         want.cipher_char, m_data.cipher_char));
                if (want.last_out != m_data.last_out)
                    note_fault($sformatf("last_out: expected %0b, got %0b",
                                         want.last_out, m_data.last_out));
            end
        end
    end

    // Hold the receiver off for a long stretch on request.
    always @(posedge aclk) begin : drive_ready
        if (freeze_seq != freeze_seen) begin
            freeze_seen = freeze_seq;
            freeze_left = FreezeLen;
        end
        if (freeze_left > 0) begin
            freeze_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt > CycleLimit) begin
            $display("playfair_stream_encrypt_test: errors");
            $finish;
        end
    end

    task automatic send_byte(in_t item);
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        encipher_byte(item);
    endtask

    task automatic drain_block();
        s_valid <= 1'b0;
        while (cipher_q.size() != 0)
            @(posedge aclk);
        repeat (Settle) @(posedge aclk);
    endtask

    task automatic load_square(key_t rows);
        for (int i = REG_KEY_ROW0; i <= REG_KEY_ROW4; i++) begin
            cfg_wen <= 1'b1;
            cfg_index <= CfgIdxW'(i);
            cfg_wdata <= rows[i];
            @(posedge aclk);
        end
        cfg_wen <= 1'b0;
        sq_rows = rows;
    endtask

    function automatic key_t shuffled_square();
        code_t pool [25];
        key_t  rows;
        code_t t;
        int    k, j;
        k = 0;
        for (int c = 0; c < 26; c++) begin
            if (code_t'(c) != CODE_J) begin
                pool[k] = code_t'(c);
                k++;
            end
        end
        for (int i = 24; i > 0; i--) begin
            j = $urandom_range(i);
            t = pool[i];
            pool[i] = pool[j];
            pool[j] = t;
        end
        for (int i = 0; i < 25; i++)
            rows[i / 5][CodeW * (i % 5) +: CodeW] = pool[i];
        return rows;
    endfunction

    function automatic key_t raw_square();
        key_t rows;
        for (int r = 0; r < KeyRows; r++)
            rows[r] = KeyW'($urandom);
        return rows;
    endfunction

    function automatic in_t pick_byte(logic eom);
        in_t item;
        int  roll;
        roll = $urandom_range(99);
        if (roll < 12) begin
            item.char_in = 8'($urandom_range(255));
        end else if (roll < 24) begin
            item.char_in = last_pick ^ (8'($urandom_range(1)) << 5);
        end else if (roll < 32) begin
            item.char_in = $urandom_range(1) ? "J" : "j";
        end else begin
            item.char_in = 8'($urandom_range(25)) + ($urandom_range(1) ? ChUpperA : ChLowerA);
            last_pick = item.char_in;
        end
        item.end_of_message = eom;
        return item;
    endfunction

    task automatic send_message(int len);
        for (int k = 1; k <= len; k++)
            send_byte(pick_byte(k == len));
    endtask

    task automatic run_messages(int budget);
        int sent, len;
        sent = 0;
        while (sent < budget) begin
            len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 14);
            send_message(len);
            sent += len;
        end
    endtask

    task automatic test_directed();
        logic [7:0] text [22];
        in_t        item;
        text = '{"M", "H", "M", "U", "M", "N", 8'h40, "A", 8'h5B, "Z", 8'h60,
                 "a", 8'h7B, "z", "J", "j", "L", "L", 8'h00, 8'hFF, "X", "X"};
        src_idle_pct = 0;
        snk_stall_pct = 0;
        for (int k = 0; k < 22; k++) begin
            item.char_in = text[k];
            item.end_of_message = (k == 15 || k == 18 || k == 19 || k == 21);
            send_byte(item);
        end
        drain_block();
    endtask

    task automatic test_key_extremes();
        load_square('0);
        run_messages(20);
        drain_block();
        load_square('1);
        run_messages(20);
        drain_block();
    endtask

    task automatic test_random_squares();
        int idle_tab  [4];
        int stall_tab [4];
        idle_tab = '{0, 49, 0, 6};
        stall_tab = '{0, 0, 49, 6};
        for (int p = 0; p < 4; p++) begin
            src_idle_pct = idle_tab[p];
            snk_stall_pct = stall_tab[p];
            case (p)
                0, 2: begin
                    load_square(shuffled_square());
                end
                1: begin
                    load_square(raw_square());
                end
                default: begin
                    load_square(KeyReset);
                end
            endcase
            run_messages(90);
            drain_block();
        end
    endtask

    task automatic test_output_hold();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        freeze_seq++;
        send_message(40);
        drain_block();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_key_extremes();
        test_random_squares();
        test_output_hold();
        drain_block();
        if (fault_cnt == 0)
            $display("playfair_stream_encrypt_test: clean");
        else
            $display("playfair_stream_encrypt_test: errors");
        $finish;
    end

endmodule
